@@ hdl/timer_expiry_min_heap_top_macros.svh @@
// Assertion macros shared by the timer expiry heap RTL.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef TIMER_EXPIRY_MIN_HEAP_TOP_MACROS_SVH
`define TIMER_EXPIRY_MIN_HEAP_TOP_MACROS_SVH
`define TEMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TEMH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`endif

@@ hdl/temh_pkg.sv @@
// Package of the timer expiry heap: command and status codes, default sizes.
// No dependencies.
package temh_pkg;

  localparam int MAX_TIMERS  = 32;
  localparam int MAX_WAITERS = 15;
  localparam int TIME_WIDTH  = 64;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [2:0] {
    CMD_SET        = 3'd0,
    CMD_WAIT       = 3'd1,
    CMD_CANCEL_ALL = 3'd2,
    CMD_CANCEL_ONE = 3'd3,
    CMD_EXPIRE     = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE     = 3'd0,
    ST_EXPIRED  = 3'd1,
    ST_CANCELED = 3'd2,
    ST_DONE_NOW = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

endpackage

@@ hdl/temh_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module temh_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/timer_expiry_min_heap_top.sv @@
// Top level of the timer expiry heap: indexed binary min-heap of timers.
// Depends on temh_pkg, temh_ram and timer_expiry_min_heap_top_macros.svh.
//
//  Channel   Signals                                      Handshake
//  command   command_i, timer_id_i, time_value_i          start high, busy low
//  result    result_timer_o .. last_o                     result_valid_o, one cycle
//
// A command without heap work passes dispatch, record write-back, a root read and the drain
// of its results. An insert or update adds final compares, a placement, and per level moved
// a heap read (down: one per child), a compare and a slot write; a removal adds S_RM, plus
// S_RMLAST and the sift when the last entry moves in. Expire checks the root and pops each
// timer with its record, removal and write-back. Reset clears the heap count and per-timer
// valid bits at once. Results leave on consecutive cycles and cannot be stalled.
`include "timer_expiry_min_heap_top_macros.svh"
module timer_expiry_min_heap_top #(
  parameter int MaxTimers  = temh_pkg::MAX_TIMERS,
  parameter int MaxWaiters = temh_pkg::MAX_WAITERS,
  parameter int TimeWidth  = temh_pkg::TIME_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command_i,
  input  logic [4:0]         timer_id_i,
  input  logic signed [63:0] time_value_i,
  output logic               result_valid_o,
  output logic [4:0]         result_timer_o,
  output logic [2:0]         status_o,
  output logic [3:0]         waiters_released_o,
  output logic               earliest_changed_o,
  output logic signed [63:0] nearest_expiry_o,
  output logic               heap_empty_o,
  output logic               last_o
);

  localparam int IDX_W  = $clog2(MaxTimers);
  localparam int SLOT_W = $clog2(MaxTimers + 1);
  localparam int CW     = IDX_W + 2;
  localparam int WC_W   = $clog2(MaxWaiters + 1);
  localparam int QDEPTH = temh_pkg::MAX_RESULTS;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int NRES_W = $clog2(QDEPTH + 1);

  localparam logic signed [TimeWidth-1:0] TMAX = {1'b0, {(TimeWidth-1){1'b1}}};
  localparam logic signed [TimeWidth-1:0] TMIN = {1'b1, {(TimeWidth-1){1'b0}}};

  typedef struct packed {
    logic [SLOT_W-1:0]           slot;
    logic signed [TimeWidth-1:0] expiry;
    logic [WC_W-1:0]             waiters;
    logic                        pending;
  } trec_t;

  typedef struct packed {
    logic signed [TimeWidth-1:0] key;
    logic [IDX_W-1:0]            owner;
  } hent_t;

  typedef struct packed {
    logic [4:0]        timer;
    temh_pkg::status_e status;
    logic [WC_W-1:0]   rel;
    logic              ec;
  } qent_t;

  localparam trec_t TREC_RST = '{slot: SLOT_W'(MaxTimers), expiry: TMIN,
                                  waiters: '0, pending: 1'b0};

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_RM, S_RMLAST, S_UP, S_UPCMP, S_SLOTW, S_DOWN, S_DC1, S_DC2,
    S_PLACE, S_FIN, S_EXPCHK, S_EXPCMP, S_EXPREC, S_NEAR, S_NEAR2, S_DRAIN
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [2:0]                  cmd_q, cmd_d;
  logic signed [TimeWidth-1:0] t_q, t_d;
  logic [IDX_W-1:0]            rid_q, rid_d;
  logic                        wrec_q, wrec_d;
  trec_t                       rec_q, rec_d;
  logic [SLOT_W-1:0]           cnt_q, cnt_d;
  logic [IDX_W-1:0]            pos_q, pos_d;
  logic signed [TimeWidth-1:0] mkey_q, mkey_d;
  logic [IDX_W-1:0]            mown_q, mown_d;
  logic                        moved_q, moved_d;
  logic                        mrec_q, mrec_d;
  hent_t                       chld_q, chld_d;
  logic [IDX_W-1:0]            sown_q, sown_d;
  logic [IDX_W-1:0]            spos_q, spos_d;
  logic [4:0]                  res_tmr_q, res_tmr_d;
  temh_pkg::status_e           res_st_q, res_st_d;
  logic [WC_W-1:0]             res_rel_q, res_rel_d;
  logic                        res_ec_q, res_ec_d;
  logic [NRES_W-1:0]           nres_q, nres_d;
  logic [QA_W-1:0]             rptr_q, rptr_d;
  logic signed [TimeWidth-1:0] nearest_q, nearest_d;
  logic                        empty_q, empty_d;
  logic                        ovld_q, ovld_d;
  logic                        olast_q, olast_d;
  logic [MaxTimers-1:0]        tvld_q;
  logic                        rvld_q;

  logic                     hwe, twe, qwe;
  logic [IDX_W-1:0]         hwaddr, hraddr, twaddr, traddr;
  hent_t                    hwdata, hrd;
  trec_t                    twdata, trd;
  qent_t                    qwdata, qrd;
  logic [QA_W-1:0]          qwaddr, qraddr;
  logic [$bits(hent_t)-1:0] h_rdata;
  logic [$bits(trec_t)-1:0] t_rdata;
  logic [$bits(qent_t)-1:0] q_rdata;
  logic [7:0]               rel8;

  trec_t            r;
  logic             inh;
  logic [CW-1:0]    c, c1;
  logic [IDX_W-1:0] parent, midx;
  logic             take_second;
  hent_t            msel;

  temh_ram #(.Width($bits(hent_t)), .Depth(MaxTimers)) u_heap_ram (
    .clk_i, .we_i(hwe), .waddr_i(hwaddr), .wdata_i(hwdata), .raddr_i(hraddr),
    .rdata_o(h_rdata)
  );

  temh_ram #(.Width($bits(trec_t)), .Depth(MaxTimers)) u_timer_ram (
    .clk_i, .we_i(twe), .waddr_i(twaddr), .wdata_i(twdata), .raddr_i(traddr),
    .rdata_o(t_rdata)
  );

  temh_ram #(.Width($bits(qent_t)), .Depth(QDEPTH)) u_result_ram (
    .clk_i, .we_i(qwe), .waddr_i(qwaddr), .wdata_i(qwdata), .raddr_i(qraddr),
    .rdata_o(q_rdata)
  );

  assign hrd = hent_t'(h_rdata);
  assign trd = rvld_q ? trec_t'(t_rdata) : TREC_RST;
  assign qrd = qent_t'(q_rdata);

  assign c           = {1'b0, pos_q, 1'b1};
  assign c1          = c + CW'(1);
  assign parent      = IDX_W'((pos_q - 1'b1) >> 1);
  assign take_second = (state_q == S_DC2) && !($signed(chld_q.key) < $signed(hrd.key));
  assign msel        = ((state_q == S_DC1) || take_second) ? hrd : chld_q;
  assign midx        = take_second ? c1[IDX_W-1:0] : c[IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    cmd_d     = cmd_q;
    t_d       = t_q;
    rid_d     = rid_q;
    wrec_d    = wrec_q;
    rec_d     = rec_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    mkey_d    = mkey_q;
    mown_d    = mown_q;
    moved_d   = moved_q;
    mrec_d    = mrec_q;
    chld_d    = chld_q;
    sown_d    = sown_q;
    spos_d    = spos_q;
    res_tmr_d = res_tmr_q;
    res_st_d  = res_st_q;
    res_rel_d = res_rel_q;
    res_ec_d  = res_ec_q;
    nres_d    = nres_q;
    rptr_d    = rptr_q;
    nearest_d = nearest_q;
    empty_d   = empty_q;
    ovld_d    = 1'b0;
    olast_d   = 1'b0;
    hwe       = 1'b0;
    hwaddr    = pos_q;
    hwdata    = '{key: mkey_q, owner: mown_q};
    hraddr    = '0;
    twe       = 1'b0;
    twaddr    = rid_q;
    twdata    = rec_q;
    traddr    = '0;
    qwe       = 1'b0;
    qwaddr    = nres_q[QA_W-1:0];
    qwdata    = '{timer: res_tmr_q, status: res_st_q, rel: res_rel_q,
                  ec: res_ec_q && (rec_q.slot == '0)};
    qraddr    = rptr_q;
    r         = trd;
    inh       = trd.slot < cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d     = command_i;
          t_d       = time_value_i[TimeWidth-1:0];
          nres_d    = '0;
          wrec_d    = 1'b1;
          res_ec_d  = 1'b0;
          res_tmr_d = timer_id_i;
          rid_d     = IDX_W'(timer_id_i);
          if (command_i == temh_pkg::CMD_EXPIRE) begin
            state_d = S_EXPCHK;
          end else if (command_i > temh_pkg::CMD_EXPIRE || int'(timer_id_i) >= MaxTimers) begin
            res_st_d  = temh_pkg::ST_NONE;
            res_rel_d = '0;
            wrec_d    = 1'b0;
            state_d   = S_FIN;
          end else begin
            traddr  = IDX_W'(timer_id_i);
            state_d = S_DISP;
          end
        end
      end
      S_DISP: begin
        rec_d     = r;
        state_d   = S_FIN;
        res_st_d  = temh_pkg::ST_NONE;
        res_rel_d = '0;
        unique case (temh_pkg::cmd_e'(cmd_q))
          temh_pkg::CMD_SET: begin
            rec_d.expiry  = t_q;
            rec_d.waiters = '0;
            res_rel_d     = r.waiters;
            res_st_d      = (r.waiters != '0) ? temh_pkg::ST_CANCELED : temh_pkg::ST_NONE;
            res_ec_d      = inh;
            if (inh) begin
              mkey_d  = t_q;
              mown_d  = rid_q;
              pos_d   = IDX_W'(r.slot);
              moved_d = 1'b0;
              mrec_d  = 1'b1;
              state_d = S_UP;
            end
          end
          temh_pkg::CMD_WAIT: begin
            if (!inh && ($signed(r.expiry) <= $signed(t_q))) begin
              res_st_d  = temh_pkg::ST_DONE_NOW;
              res_rel_d = WC_W'(1);
            end else if (r.waiters >= WC_W'(MaxWaiters)) begin
              res_st_d = temh_pkg::ST_OVERFLOW;
            end else begin
              rec_d.waiters = r.waiters + 1'b1;
              rec_d.pending = 1'b1;
              if (!inh && (cnt_q < SLOT_W'(MaxTimers))) begin
                pos_d    = IDX_W'(cnt_q);
                cnt_d    = cnt_q + 1'b1;
                mkey_d   = r.expiry;
                mown_d   = rid_q;
                moved_d  = 1'b0;
                mrec_d   = 1'b1;
                res_ec_d = 1'b1;
                state_d  = S_UP;
              end
            end
          end
          temh_pkg::CMD_CANCEL_ALL: begin
            if (r.pending) begin
              rec_d.pending = 1'b0;
              if (inh || (r.waiters != '0)) begin
                res_rel_d     = r.waiters;
                res_st_d      = (r.waiters != '0) ? temh_pkg::ST_CANCELED : temh_pkg::ST_NONE;
                rec_d.waiters = '0;
                state_d       = S_RM;
              end
            end
          end
          temh_pkg::CMD_CANCEL_ONE: begin
            if (r.pending && (r.waiters != '0)) begin
              rec_d.waiters = r.waiters - 1'b1;
              res_st_d      = temh_pkg::ST_CANCELED;
              res_rel_d     = WC_W'(1);
              if (r.waiters == WC_W'(1)) begin
                rec_d.pending = 1'b0;
                state_d       = S_RM;
              end
            end
          end
          default: begin
            state_d = S_FIN;
          end
        endcase
      end
      S_RM: begin
        state_d = S_FIN;
        if (rec_q.slot < cnt_q) begin
          cnt_d      = cnt_q - 1'b1;
          rec_d.slot = SLOT_W'(MaxTimers);
          if (rec_q.slot != cnt_q - 1'b1) begin
            hraddr  = IDX_W'(cnt_q - 1'b1);
            pos_d   = IDX_W'(rec_q.slot);
            moved_d = 1'b0;
            mrec_d  = 1'b0;
            state_d = S_RMLAST;
          end
        end
      end
      S_RMLAST: begin
        mkey_d  = hrd.key;
        mown_d  = hrd.owner;
        state_d = S_UP;
      end
      S_UP: begin
        if (pos_q == '0) begin
          state_d = moved_q ? S_PLACE : S_DOWN;
        end else begin
          hraddr  = parent;
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if ($signed(mkey_q) < $signed(hrd.key)) begin
          hwe     = 1'b1;
          hwdata  = hrd;
          traddr  = hrd.owner;
          sown_d  = hrd.owner;
          spos_d  = pos_q;
          pos_d   = parent;
          moved_d = 1'b1;
          ret_d   = S_UP;
          state_d = S_SLOTW;
        end else begin
          state_d = moved_q ? S_PLACE : S_DOWN;
        end
      end
      S_SLOTW: begin
        r.slot  = SLOT_W'(spos_q);
        twe     = 1'b1;
        twaddr  = sown_q;
        twdata  = r;
        state_d = ret_q;
      end
      S_DOWN: begin
        if (c >= CW'(cnt_q)) begin
          state_d = S_PLACE;
        end else begin
          hraddr  = c[IDX_W-1:0];
          state_d = S_DC1;
        end
      end
      S_DC1, S_DC2: begin
        if (state_q == S_DC1) begin
          chld_d = hrd;
        end
        if ((state_q == S_DC1) && (c1 < CW'(cnt_q))) begin
          hraddr  = c1[IDX_W-1:0];
          state_d = S_DC2;
        end else if ($signed(mkey_q) < $signed(msel.key)) begin
          state_d = S_PLACE;
        end else begin
          hwe     = 1'b1;
          hwdata  = msel;
          traddr  = msel.owner;
          sown_d  = msel.owner;
          spos_d  = pos_q;
          pos_d   = midx;
          ret_d   = S_DOWN;
          state_d = S_SLOTW;
        end
      end
      S_PLACE: begin
        hwe = 1'b1;
        if (mrec_q) begin
          rec_d.slot = SLOT_W'(pos_q);
          state_d    = S_FIN;
        end else begin
          traddr  = mown_q;
          sown_d  = mown_q;
          spos_d  = pos_q;
          ret_d   = S_FIN;
          state_d = S_SLOTW;
        end
      end
      S_FIN: begin
        twe    = wrec_q;
        qwe    = 1'b1;
        nres_d = nres_q + 1'b1;
        state_d = (cmd_q == temh_pkg::CMD_EXPIRE) ? S_EXPCHK : S_NEAR;
      end
      S_EXPCHK: begin
        if ((nres_q == NRES_W'(QDEPTH)) || (cnt_q == '0)) begin
          if (nres_q == '0) begin
            qwe    = 1'b1;
            qwdata = '{timer: '0, status: temh_pkg::ST_NONE, rel: '0, ec: 1'b0};
            nres_d = nres_q + 1'b1;
          end
          state_d = S_NEAR;
        end else begin
          hraddr  = '0;
          state_d = S_EXPCMP;
        end
      end
      S_EXPCMP: begin
        if ($signed(hrd.key) <= $signed(t_q)) begin
          rid_d   = hrd.owner;
          traddr  = hrd.owner;
          state_d = S_EXPREC;
        end else begin
          if (nres_q == '0) begin
            qwe    = 1'b1;
            qwdata = '{timer: '0, status: temh_pkg::ST_NONE, rel: '0, ec: 1'b0};
            nres_d = nres_q + 1'b1;
          end
          state_d = S_NEAR;
        end
      end
      S_EXPREC: begin
        rec_d         = r;
        rec_d.waiters = '0;
        rec_d.pending = 1'b0;
        res_tmr_d     = 5'(rid_q);
        res_st_d      = temh_pkg::ST_EXPIRED;
        res_rel_d     = r.waiters;
        res_ec_d      = 1'b0;
        wrec_d        = 1'b1;
        state_d       = S_RM;
      end
      S_NEAR: begin
        hraddr  = '0;
        state_d = S_NEAR2;
      end
      S_NEAR2: begin
        nearest_d = (cnt_q != '0) ? hrd.key : TMAX;
        empty_d   = (cnt_q == '0);
        rptr_d    = '0;
        state_d   = S_DRAIN;
      end
      S_DRAIN: begin
        ovld_d  = 1'b1;
        olast_d = ({1'b0, rptr_q} + 1'b1) == nres_q;
        rptr_d  = rptr_q + 1'b1;
        if (olast_d) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      cmd_q     <= '0;
      t_q       <= '0;
      rid_q     <= '0;
      wrec_q    <= 1'b0;
      rec_q     <= TREC_RST;
      cnt_q     <= '0;
      pos_q     <= '0;
      mkey_q    <= '0;
      mown_q    <= '0;
      moved_q   <= 1'b0;
      mrec_q    <= 1'b0;
      chld_q    <= '0;
      sown_q    <= '0;
      spos_q    <= '0;
      res_tmr_q <= '0;
      res_st_q  <= temh_pkg::ST_NONE;
      res_rel_q <= '0;
      res_ec_q  <= 1'b0;
      nres_q    <= '0;
      rptr_q    <= '0;
      nearest_q <= TMAX;
      empty_q   <= 1'b1;
      ovld_q    <= 1'b0;
      olast_q   <= 1'b0;
      tvld_q    <= '0;
      rvld_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      cmd_q     <= cmd_d;
      t_q       <= t_d;
      rid_q     <= rid_d;
      wrec_q    <= wrec_d;
      rec_q     <= rec_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      mkey_q    <= mkey_d;
      mown_q    <= mown_d;
      moved_q   <= moved_d;
      mrec_q    <= mrec_d;
      chld_q    <= chld_d;
      sown_q    <= sown_d;
      spos_q    <= spos_d;
      res_tmr_q <= res_tmr_d;
      res_st_q  <= res_st_d;
      res_rel_q <= res_rel_d;
      res_ec_q  <= res_ec_d;
      nres_q    <= nres_d;
      rptr_q    <= rptr_d;
      nearest_q <= nearest_d;
      empty_q   <= empty_d;
      ovld_q    <= ovld_d;
      olast_q   <= olast_d;
      rvld_q    <= tvld_q[traddr];
      if (twe) begin
        tvld_q[twaddr] <= 1'b1;
      end
    end
  end

  assign rel8 = 8'(qrd.rel);

  assign busy               = (state_q != S_IDLE);
  assign result_valid_o     = ovld_q;
  assign result_timer_o     = qrd.timer;
  assign status_o           = qrd.status;
  assign waiters_released_o = (rel8 > 8'd15) ? 4'd15 : rel8[3:0];
  assign earliest_changed_o = qrd.ec;
  assign nearest_expiry_o   = 64'(nearest_q);
  assign heap_empty_o       = empty_q;
  assign last_o             = olast_q;

  `TEMH_ASSERT(a_cnt_range, cnt_q <= SLOT_W'(MaxTimers), "Heap count above capacity.")
  `TEMH_ASSERT(a_nres_range, nres_q <= NRES_W'(QDEPTH), "Result queue overfilled.")
  `TEMH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy.")
  `TEMH_ASSERT_NEXT(a_burst, result_valid_o && !last_o, result_valid_o, "Result burst broke off.")
  `TEMH_ASSERT(a_drain_nonempty, (state_q == S_DRAIN) |-> (nres_q != '0), "Drain with no results.")

endmodule
